// ===== rtl/lcb_pkg.sv =====
// Shared types and constants for the levels, contrast and brightness core.
package lcb_pkg;

	// Register indexes on the configuration port
	localparam logic [2:0] REG_BRIGHTNESS = 3'd0;
	localparam logic [2:0] REG_RED_LOW    = 3'd1;
	localparam logic [2:0] REG_RED_HIGH   = 3'd2;
	localparam logic [2:0] REG_GREEN_LOW  = 3'd3;
	localparam logic [2:0] REG_GREEN_HIGH = 3'd4;
	localparam logic [2:0] REG_BLUE_LOW   = 3'd5;
	localparam logic [2:0] REG_BLUE_HIGH  = 3'd6;

	// Channel value limits
	localparam logic [7:0] PIX_MAX = 8'd255;
	localparam logic [7:0] PIX_MIN = 8'd0;

	// Divider steps per table entry (quotient never exceeds 8 bits)
	localparam logic [2:0] DIV_LAST_STEP = 3'd7;

	// Table fill sequencer state, shared by all channel units
	typedef struct packed {
		logic       active;
		logic [7:0] addr;
		logic [2:0] step;
	} fill_ctl_t;

endpackage

// ===== rtl/lcb_ram.sv =====
// Generic simple dual-port RAM with a registered read port.
module lcb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read port: data holds while re is low
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/lcb_chan.sv =====
// One color channel: stretch table in RAM, its fill divider and its read port.
module lcb_chan (
	input  logic              clk,
	input  lcb_pkg::fill_ctl_t fill,
	input  logic [7:0]        win_low,
	input  logic [7:0]        win_high,
	input  logic              rd_en,
	input  logic [7:0]        rd_addr,
	output logic [7:0]        rd_data
);
	import lcb_pkg::*;

	logic [15:0] rem_q;
	logic [7:0]  quo_q;

	logic [7:0]  offs;
	logic [7:0]  span;
	logic [15:0] num;
	logic [15:0] rem_cur;
	logic [7:0]  quo_cur;
	logic [2:0]  bit_pos;
	logic [15:0] div_sh;
	logic [16:0] trial;
	logic        fits;
	logic [15:0] rem_nxt;
	logic [7:0]  quo_nxt;
	logic        below;
	logic        above;
	logic        open_win;
	logic [7:0]  entry;
	logic        wr_en;

	// Numerator 255*(v-low) and divisor high-low for the entry being filled
	assign offs = fill.addr - win_low;
	assign span = win_high - win_low;
	assign num  = {offs, 8'd0} - {8'd0, offs};

	// One restoring step per cycle, quotient bit 7 first
	assign bit_pos = DIV_LAST_STEP - fill.step;
	assign rem_cur = (fill.step == 3'd0) ? num : rem_q;
	assign quo_cur = (fill.step == 3'd0) ? 8'd0 : quo_q;
	assign div_sh  = {8'd0, span} << bit_pos;
	assign trial   = {1'b0, rem_cur} - {1'b0, div_sh};
	assign fits    = ~trial[16];
	assign rem_nxt = fits ? trial[15:0] : rem_cur;
	assign quo_nxt = quo_cur | ({7'd0, fits} << bit_pos);

	always_ff @(posedge clk) begin
		if (fill.active) begin
			rem_q <= rem_nxt;
			quo_q <= quo_nxt;
		end
	end

	// Clamp outside the window (below first); inside an empty window the entry is zero
	assign below    = fill.addr < win_low;
	assign above    = fill.addr > win_high;
	assign open_win = win_high > win_low;

	always_comb begin
		priority if (below) begin
			entry = PIX_MIN;
		end else if (above) begin
			entry = PIX_MAX;
		end else if (open_win) begin
			entry = quo_nxt;
		end else begin
			entry = PIX_MIN;
		end
	end

	assign wr_en = fill.active && (fill.step == DIV_LAST_STEP);

	lcb_ram #(
		.WIDTH(8),
		.DEPTH(256)
	) u_lut (
		.clk  (clk),
		.we   (wr_en),
		.waddr(fill.addr),
		.wdata(entry),
		.re   (rd_en),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

endmodule

// ===== rtl/levels_contrast_brightness_core.sv =====
// Top level: per-channel levels stretch through RAM tables plus saturating brightness.
//
//  channel   handshake                  payload
//  pixel     pixel_valid / pixel_ready  red, green, blue
//  result    result_valid/result_ready  red_out, green_out, blue_out
//  config    APB psel/penable/pwrite    paddr, pwdata, prdata
//
// One word per clock sustained while result_ready is high and no rebuild runs;
// a word passes the table RAM read, then the brightness add and output register.
// Each channel keeps a 256-entry table in RAM; after reset and after any window
// write the tables are rebuilt by an 8-step divider, with pixel_ready low while
// it runs. Brightness writes take effect at once. A stalled result holds the read.
module levels_contrast_brightness_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        pixel_valid,
	output logic        pixel_ready,
	input  logic [7:0]  red,
	input  logic [7:0]  green,
	input  logic [7:0]  blue,
	output logic        result_valid,
	input  logic        result_ready,
	output logic [7:0]  red_out,
	output logic [7:0]  green_out,
	output logic [7:0]  blue_out
);
	import lcb_pkg::*;

	logic [8:0] bright_q;
	logic [7:0] red_low_q, red_high_q;
	logic [7:0] green_low_q, green_high_q;
	logic [7:0] blue_low_q, blue_high_q;

	fill_ctl_t  fill_q;
	logic       valid_s1;
	logic       out_valid_q;
	logic [7:0] red_out_q, green_out_q, blue_out_q;

	logic       cfg_wr;
	logic [2:0] cfg_idx;
	logic       win_wr;
	logic       advance;
	logic       take;
	logic [7:0] red_lut, green_lut, blue_lut;

	// Configuration port
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_idx = paddr[4:2];
	assign win_wr  = cfg_wr && (cfg_idx != REG_BRIGHTNESS) && (cfg_idx <= REG_BLUE_HIGH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bright_q     <= 9'd0;
			red_low_q    <= PIX_MIN;
			red_high_q   <= PIX_MAX;
			green_low_q  <= PIX_MIN;
			green_high_q <= PIX_MAX;
			blue_low_q   <= PIX_MIN;
			blue_high_q  <= PIX_MAX;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_BRIGHTNESS: bright_q     <= pwdata[8:0];
				REG_RED_LOW:    red_low_q    <= pwdata[7:0];
				REG_RED_HIGH:   red_high_q   <= pwdata[7:0];
				REG_GREEN_LOW:  green_low_q  <= pwdata[7:0];
				REG_GREEN_HIGH: green_high_q <= pwdata[7:0];
				REG_BLUE_LOW:   blue_low_q   <= pwdata[7:0];
				REG_BLUE_HIGH:  blue_high_q  <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	// Register readback
	always_comb begin
		unique case (cfg_idx)
			REG_BRIGHTNESS: prdata = {23'd0, bright_q};
			REG_RED_LOW:    prdata = {24'd0, red_low_q};
			REG_RED_HIGH:   prdata = {24'd0, red_high_q};
			REG_GREEN_LOW:  prdata = {24'd0, green_low_q};
			REG_GREEN_HIGH: prdata = {24'd0, green_high_q};
			REG_BLUE_LOW:   prdata = {24'd0, blue_low_q};
			REG_BLUE_HIGH:  prdata = {24'd0, blue_high_q};
			default:        prdata = 32'd0;
		endcase
	end

	// Table fill sequencer: 8 divider steps per entry, restarts on window write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q.active <= 1'b1;
			fill_q.addr   <= 8'd0;
			fill_q.step   <= 3'd0;
		end else if (win_wr) begin
			fill_q.active <= 1'b1;
			fill_q.addr   <= 8'd0;
			fill_q.step   <= 3'd0;
		end else if (fill_q.active) begin
			fill_q.step <= fill_q.step + 3'd1;
			if (fill_q.step == DIV_LAST_STEP) begin
				fill_q.addr <= fill_q.addr + 8'd1;
				if (fill_q.addr == PIX_MAX) begin
					fill_q.active <= 1'b0;
				end
			end
		end
	end

	// Pipeline control: s1 is the table read, then the output register
	assign advance     = !out_valid_q || result_ready;
	assign pixel_ready = !fill_q.active && (advance || !valid_s1);
	assign take        = pixel_valid && pixel_ready;

	lcb_chan u_red (
		.clk     (clk),
		.fill    (fill_q),
		.win_low (red_low_q),
		.win_high(red_high_q),
		.rd_en   (take),
		.rd_addr (red),
		.rd_data (red_lut)
	);

	lcb_chan u_green (
		.clk     (clk),
		.fill    (fill_q),
		.win_low (green_low_q),
		.win_high(green_high_q),
		.rd_en   (take),
		.rd_addr (green),
		.rd_data (green_lut)
	);

	lcb_chan u_blue (
		.clk     (clk),
		.fill    (fill_q),
		.win_low (blue_low_q),
		.win_high(blue_high_q),
		.rd_en   (take),
		.rd_addr (blue),
		.rd_data (blue_lut)
	);

	// Add signed brightness and saturate to 0..255
	function automatic logic [7:0] add_sat(input logic [7:0] v, input logic [8:0] b);
		logic [10:0] sum;
		sum = {3'd0, v} + {{2{b[8]}}, b};
		if (sum[10]) begin
			return PIX_MIN;
		end else if (sum[9:8] != 2'd0) begin
			return PIX_MAX;
		end else begin
			return sum[7:0];
		end
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			red_out_q   <= add_sat(red_lut, bright_q);
			green_out_q <= add_sat(green_lut, bright_q);
			blue_out_q  <= add_sat(blue_lut, bright_q);
		end
	end

	assign result_valid = out_valid_q;
	assign red_out      = red_out_q;
	assign green_out    = green_out_q;
	assign blue_out     = blue_out_q;

endmodule
